FILE: design/tmc_pkg.sv
// Shared constants and types for the text-mode console.
package tmc_pkg;

  // Default geometry
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Request modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HIGH  = 8'h80;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

FILE: design/tmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/text_mode_console.sv
// Text-mode console top level: cursor, sequencer and frame buffer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | request   | in_valid_i/in_stall_o | mode_i, char_code_i, cell_index_i
//   out     | result    | out_valid_o/out_stall_i | cursor_col_o/row_o/location_o, cell_data_o
//   cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_data_i (text attribute)
//
// Put and unused-mode requests pass through the done state to a loaded result; a read
// passes through the read state first. A put that scrolls walks the buffer one cell a cycle
// through the single RAM port pair: copy pass, drain of the last copied cell, blank pass.
// Clear blanks every cell and homes the cursor. After reset a clearing pass blanks the buffer
// while no request is taken; config writes are taken always.
// A finished result waits in the output register; a new request is taken meanwhile,
// and the next result is held back until the output register is free.
module text_mode_console
  import tmc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [10:0]       cell_index_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o,
  output logic [10:0]       cursor_location_o,
  output logic [CELL_W-1:0] cell_data_o,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ATTR_W-1:0] cfg_data_i
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NW     = $clog2(COLUMNS + TAB_STOP);
  localparam int RW1    = $clog2(ROWS + 1);
  localparam int XW     = (AW > 11) ? AW : 11;
  localparam int TAB_K  = (COLUMNS - 1) / TAB_STOP + 1;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);

  // Smallest tab stop strictly above the column
  function automatic logic [NW-1:0] tab_next(input logic [NW-1:0] c);
    logic [NW-1:0] r;
    r = NW'(TAB_K * TAB_STOP);
    for (int k = TAB_K; k >= 1; k--) begin
      if (NW'(k * TAB_STOP) > c) begin
        r = NW'(k * TAB_STOP);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic              init_q;
  logic [AW-1:0]     cnt_q;
  logic              pend_q;
  logic [AW-1:0]     pwa_q;
  logic              rd_ok_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CELL_W-1:0] data_q;

  logic              out_valid_q;
  logic [6:0]        out_col_q;
  logic [4:0]        out_row_q;
  logic [10:0]       out_loc_q;
  logic [CELL_W-1:0] out_data_q;

  logic              accept;
  logic              out_free;
  logic [AW-1:0]     cur_loc;

  logic [NW-1:0]     col_x;
  logic [RW1-1:0]    row_x;
  logic              printable;
  logic              scroll;

  logic [XW-1:0]     idx_x;
  logic              idx_ok;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_loc  = AW'(row_q) * COLS_A + AW'(col_q);

  assign idx_x  = XW'(cell_index_i);
  assign idx_ok = idx_x < XW'(CELLS);

  assign printable = (char_code_i >= CH_SPACE) && (char_code_i < CH_HIGH);

  // Cursor update for a put request
  always_comb begin
    col_x = NW'(col_q);
    row_x = RW1'(row_q);
    if (char_code_i == CH_BS) begin
      if (col_q != '0) begin
        col_x = col_x - NW'(1);
      end
    end else if (char_code_i == CH_TAB) begin
      col_x = tab_next(col_x);
    end else if (char_code_i == CH_CR) begin
      col_x = '0;
    end else if (char_code_i == CH_LF) begin
      col_x = '0;
      row_x = row_x + RW1'(1);
    end else if (printable) begin
      col_x = col_x + NW'(1);
    end
    if (col_x >= NW'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + RW1'(1);
    end
  end

  assign scroll = row_x >= RW1'(ROWS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LAST_CELL) begin
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_PUT:   state_d = scroll ? ST_COPY : ST_DONE;
            MODE_CLEAR: state_d = ST_CLEAR;
            MODE_READ:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_COPY: begin
        if (cnt_q == COPY_LAST) begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (!pend_q && cnt_q == LAST_CELL) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM port control and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = BLANK_CELL;
    ram_raddr = cnt_q + COLS_A;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        ram_we    = accept && (mode_i == MODE_PUT) && printable;
        ram_waddr = cur_loc;
        ram_wdata = {attr_q, char_code_i};
        ram_raddr = AW'(idx_x);
      end
      ST_COPY: begin
        ram_we    = pend_q;
        ram_waddr = pwa_q;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (pend_q) begin
          ram_waddr = pwa_q;
          ram_wdata = ram_rdata;
        end
      end
      ST_READ, ST_DONE: ram_we = 1'b0;
      default: ram_we = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end

      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == LAST_CELL) begin
            init_q <= 1'b0;
          end
        end
        ST_IDLE: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          if (accept) begin
            unique case (mode_i)
              MODE_PUT: begin
                col_q <= CW'(col_x);
                row_q <= scroll ? RW'(ROWS - 1) : RW'(row_x);
              end
              MODE_CLEAR: begin
                col_q <= '0;
                row_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_COPY: begin
          pend_q <= 1'b1;
          cnt_q  <= cnt_q + AW'(1);
        end
        ST_BLANK: begin
          // Drain the last copied cell before blanking the bottom row
          if (pend_q) begin
            pend_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        default: ;
      endcase

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COPY) begin
      pwa_q <= cnt_q;
    end
    if (accept) begin
      data_q  <= '0;
      rd_ok_q <= idx_ok;
    end
    if (state_q == ST_READ) begin
      data_q <= rd_ok_q ? ram_rdata : '0;
    end
    if (state_q == ST_DONE && out_free) begin
      out_col_q  <= 7'(col_q);
      out_row_q  <= 5'(row_q);
      out_loc_q  <= 11'(cur_loc);
      out_data_q <= data_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_location_o = out_loc_q;
  assign cell_data_o       = out_data_q;

  tmc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_frame_buffer (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: verif/text_mode_console_tb.sv
// Self-checking testbench for the text-mode console: directed table, then random requests.
`timescale 1ns / 1ps

module text_mode_console_tb
  import tmc_pkg::*;
();

  localparam int COLS      = COLUMNS_DEF;
  localparam int LINES     = ROWS_DEF;
  localparam int TAB_WIDTH = TAB_STOP_DEF;
  localparam int CELLS     = COLS * LINES;

  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 70;
  localparam int DIR_ROWS       = 28;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [6:0]        col;
    logic [4:0]        row;
    logic [10:0]       loc;
    logic [CELL_W-1:0] data;
  } cursor_result_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] code;
    logic [10:0]       idx;
    logic              typed;
    cursor_result_t    want;
  } stim_row_t;

  localparam cursor_result_t NO_CHECK    = '0;
  localparam cursor_result_t HOME_RESULT = '{7'd0, 5'd0, 11'd0, 16'h0000};
  localparam cursor_result_t HOME_BLANK  = '{7'd0, 5'd0, 11'd0, BLANK_CELL};

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        mode_i = MODE_PUT;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [10:0]       cell_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [6:0]        cursor_col_o;
  logic [4:0]        cursor_row_o;
  logic [10:0]       cursor_location_o;
  logic [CELL_W-1:0] cell_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i = '0;

  // Shadow console state
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       pen_col;
  int unsigned       pen_row;
  logic [ATTR_W-1:0] attr_shadow;

  cursor_result_t    pending_results [$];
  stim_row_t         directed_rows [DIR_ROWS];
  int unsigned       error_count = 0;
  bit                steady = 1'b0;

  text_mode_console #(
    .COLUMNS  (COLS),
    .ROWS     (LINES),
    .TAB_STOP (TAB_WIDTH)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_col_o      (cursor_col_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_location_o (cursor_location_o),
    .cell_data_o       (cell_data_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk = ~clk;

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
  endtask

  // Advance the shadow console by one request and return the cursor and cell it yields.
  task automatic console_apply(input logic [1:0] mode, input logic [CHAR_W-1:0] code,
                               input logic [10:0] idx, output cursor_result_t res);
    logic [CELL_W-1:0] data;
    data = '0;
    case (mode)
      MODE_PUT: begin
        if (code == CH_BS) begin
          if (pen_col > 0) pen_col--;
        end else if (code == CH_TAB) begin
          pen_col = (pen_col / TAB_WIDTH + 1) * TAB_WIDTH;
        end else if (code == CH_CR) begin
          pen_col = 0;
        end else if (code == CH_LF) begin
          pen_col = 0;
          pen_row++;
        end else if (code >= CH_SPACE && code < CH_HIGH) begin
          screen[pen_row * COLS + pen_col] = {attr_shadow, code};
          pen_col++;
        end
        if (pen_col >= COLS) begin
          pen_col = 0;
          pen_row++;
        end
        // Scroll up one line, blank the bottom line
        if (pen_row >= LINES) begin
          for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
          pen_row = LINES - 1;
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        pen_col = 0;
        pen_row = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) data = screen[idx];
      end
      default: ;
    endcase
    res.col  = pen_col[6:0];
    res.row  = pen_row[4:0];
    res.loc  = 11'(pen_row * COLS + pen_col);
    res.data = data;
  endtask

  task automatic send_request(input logic [1:0] mode, input logic [CHAR_W-1:0] code,
                              input logic [10:0] idx, input logic typed,
                              input cursor_result_t want);
    cursor_result_t predicted;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    char_code_i  <= code;
    cell_index_i <= idx;
    forever begin
      @(posedge clk);
      if (!in_stall_o) break;
    end
    console_apply(mode, code, idx, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready_o) break;
    end
    attr_shadow = value;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, then hold until every request has returned its result.
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk) out_stall_i <= !steady && ($urandom_range(99) < 6);

  always @(posedge clk) begin : check_results
    cursor_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, col %0d row %0d data %0h",
                 $time, cursor_col_o, cursor_row_o, cell_data_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("cursor_col", 16'(want.col), 16'(cursor_col_o));
        compare_field("cursor_row", 16'(want.row), 16'(cursor_row_o));
        compare_field("cursor_location", 16'(want.loc), 16'(cursor_location_o));
        compare_field("cell_data", want.data, cell_data_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       r;
    logic [1:0]        m;
    logic [CHAR_W-1:0] c;
    logic [10:0]       x;
    logic [ATTR_W-1:0] phase_attr [PHASES];

    directed_rows = '{
      '{MODE_READ,  8'h00,    11'd0,    1'b1, HOME_BLANK},
      '{MODE_READ,  8'h00,    11'd1999, 1'b1, HOME_BLANK},
      '{MODE_READ,  8'hFF,    11'd2047, 1'b1, HOME_RESULT},
      '{MODE_NONE,  8'hFF,    11'd2047, 1'b1, HOME_RESULT},
      '{MODE_PUT,   CH_BS,    11'd0,    1'b1, HOME_RESULT},
      '{MODE_PUT,   CH_SPACE, 11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   8'h7F,    11'd2047, 1'b0, NO_CHECK},
      '{MODE_PUT,   CH_HIGH,  11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   8'hFF,    11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   8'h00,    11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_BS,    11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_CR,    11'd0,    1'b0, NO_CHECK},
      '{MODE_READ,  8'h00,    11'd1,    1'b0, NO_CHECK},
      '{MODE_PUT,   8'h41,    11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_LF,    11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_PUT,   CH_TAB,   11'd0,    1'b0, NO_CHECK},
      '{MODE_CLEAR, 8'hFF,    11'd2047, 1'b1, HOME_RESULT},
      '{MODE_READ,  8'h00,    11'd0,    1'b1, HOME_BLANK}
    };
    phase_attr = '{8'h00, 8'hFF, 8'h3C, 8'($urandom), 8'hC3, 8'($urandom)};

    blank_screen();
    pen_col     = 0;
    pen_row     = 0;
    attr_shadow = ATTR_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(directed_rows[i].mode, directed_rows[i].code, directed_rows[i].idx,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_attribute(phase_attr[p]);
      steady = (p == 3);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        c = CHAR_W'($urandom);
        x = 11'($urandom);
        r = $urandom_range(99);
        if (r < 3) begin
          m = MODE_CLEAR;
        end else if (r < 23) begin
          m = MODE_READ;
          r = $urandom_range(99);
          if (r < 75) x = 11'($urandom_range(CELLS - 1));
          else if (r < 90) x = 11'(pen_row * COLS + $urandom_range(COLS - 1));
          else x = 11'($urandom_range(2047, CELLS));
        end else if (r < 26) begin
          m = MODE_NONE;
        end else begin
          m = MODE_PUT;
          r = $urandom_range(99);
          if (r < 45) c = CHAR_W'($urandom_range(8'h7F, CH_SPACE));
          else if (r < 60) c = CH_LF;
          else if (r < 70) c = CH_TAB;
          else if (r < 76) c = CH_BS;
          else if (r < 81) c = CH_CR;
        end
        sent++;
        send_request(m, c, x, 1'b0, NO_CHECK);
      end
    end
    steady = 1'b0;

    wait_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
design/tmc_pkg.sv
design/tmc_ram.sv
design/text_mode_console.sv
verif/text_mode_console_tb.sv
